// ===== sv/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants shared by the line pixel rasterizer, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_W = 6;
  localparam int DEC_W   = 10;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [DEC_W-1:0] dec_t;

  // Largest coordinate that the block will use; larger inputs saturate to it.
  localparam coord_t COORD_MAX = 6'd63;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OCT_SHALLOW_UP,
    OCT_STEEP_UP,
    OCT_SHALLOW_DOWN,
    OCT_STEEP_DOWN
  } octant_t;

  function automatic coord_t clamp_coord(coord_t v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

// ===== sv/lpr_seg_if.sv =====
// ----------------------------------------------------------------------------
// lpr_seg_if
// Segment channel: one word carries the two endpoints of a line segment.
// ----------------------------------------------------------------------------
interface lpr_seg_if;
  import lpr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);

endinterface

// ===== sv/lpr_pix_if.sv =====
// ----------------------------------------------------------------------------
// lpr_pix_if
// Pixel channel: one word carries one pixel and the end-of-segment flag.
// ----------------------------------------------------------------------------
interface lpr_pix_if;
  import lpr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                  output ready);

endinterface

// ===== sv/line_pixel_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_pixel_rasterizer
// Midpoint (Bresenham) line rasterizer: one segment in, its pixels out.
// ----------------------------------------------------------------------------
// A segment word is taken only while the block is idle. The next cycle sets
// up the deltas, the octant, the initial decision value and the two
// increments; from then on one pixel is offered per cycle while the sink takes
// each one, the first being the leftmost endpoint, and the shared decision
// adder advances the walk each time a pixel word is taken. A segment has n
// pixels (n = max(|dx|,|dy|) + 1, 1 to 64), and the input is ready again in
// the cycle after the last pixel has been taken. The pixel coordinates come
// straight from registers.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer (
  input  logic      clk,
  input  logic      rst_n,
  lpr_seg_if.sink   in_seg,
  lpr_pix_if.source out_pix
);
  import lpr_pkg::*;

  state_t  state_r, state_nxt;

  coord_t  x_r, y_r;
  coord_t  ex_r, ey_r;
  dec_t    d_r;
  dec_t    inc_a_r, inc_b_r;
  octant_t oct_r;
  coord_t  cnt_r;

  coord_t  sx, sy, exc, eyc;
  logic    swap;

  logic [COORD_W:0]        dx, ady;
  logic signed [COORD_W:0] dy;
  dec_t    dx_e, dy_e;
  logic    shallow;
  octant_t oct_set;
  dec_t    d_set, inc_a_set, inc_b_set;
  coord_t  steps;

  logic    take_a;
  dec_t    d_nxt;
  coord_t  x_nxt, y_nxt;
  logic    step_x, step_y, y_down;

  logic    in_acc, out_acc;

  assign in_acc  = in_seg.valid && in_seg.ready;
  assign out_acc = out_pix.valid && out_pix.ready;

  // Endpoints are saturated, then ordered so that x never decreases.
  always_comb begin
    sx   = clamp_coord(in_seg.start_x);
    sy   = clamp_coord(in_seg.start_y);
    exc  = clamp_coord(in_seg.end_x);
    eyc  = clamp_coord(in_seg.end_y);
    swap = sx > exc;
  end

  always_comb begin
    dx      = {1'b0, ex_r} - {1'b0, x_r};
    dy      = $signed({1'b0, ey_r}) - $signed({1'b0, y_r});
    ady     = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
    dx_e    = dec_t'({{(DEC_W-COORD_W-1){1'b0}}, dx});
    dy_e    = dec_t'({{(DEC_W-COORD_W-1){dy[COORD_W]}}, dy});
    shallow = dx >= ady;
    steps   = shallow ? dx[COORD_W-1:0] : ady[COORD_W-1:0];
    if (!dy[COORD_W]) begin
      if (shallow) begin
        oct_set   = OCT_SHALLOW_UP;
        d_set     = (dy_e <<< 1) - dx_e;
        inc_a_set = dy_e <<< 1;
      end else begin
        oct_set   = OCT_STEEP_UP;
        d_set     = dy_e - (dx_e <<< 1);
        inc_a_set = -(dx_e <<< 1);
      end
      inc_b_set = (dy_e - dx_e) <<< 1;
    end else begin
      if (shallow) begin
        oct_set   = OCT_SHALLOW_DOWN;
        d_set     = (dy_e <<< 1) + dx_e;
        inc_a_set = dy_e <<< 1;
      end else begin
        oct_set   = OCT_STEEP_DOWN;
        d_set     = dy_e + (dx_e <<< 1);
        inc_a_set = dx_e <<< 1;
      end
      inc_b_set = (dy_e + dx_e) <<< 1;
    end
  end

  // Increment a is the straight step along the major axis, increment b the
  // diagonal one; each octant has its own comparison, and on a tie only the shallow upward octant takes a.
  always_comb begin
    case (oct_r)
      OCT_SHALLOW_UP:   take_a = d_r <= 0;
      OCT_STEEP_UP:     take_a = d_r > 0;
      OCT_SHALLOW_DOWN: take_a = d_r > 0;
      OCT_STEEP_DOWN:   take_a = d_r < 0;
      default:          take_a = 1'b0;
    endcase
    y_down = (oct_r == OCT_SHALLOW_DOWN) || (oct_r == OCT_STEEP_DOWN);
    if (take_a) begin
      step_x = (oct_r == OCT_SHALLOW_UP) || (oct_r == OCT_SHALLOW_DOWN);
      step_y = !step_x;
    end else begin
      step_x = 1'b1;
      step_y = 1'b1;
    end
    d_nxt = d_r + (take_a ? inc_a_r : inc_b_r);
    x_nxt = step_x ? x_r + 1'b1 : x_r;
    if (!step_y) begin
      y_nxt = y_r;
    end else if (y_down) begin
      y_nxt = y_r - 1'b1;
    end else begin
      y_nxt = y_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_EMIT;
      ST_EMIT:  if (out_acc && (cnt_r == '0)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_seg.ready       = state_r == ST_IDLE;
    out_pix.valid      = state_r == ST_EMIT;
    out_pix.pixel_x    = x_r;
    out_pix.pixel_y    = y_r;
    out_pix.last_pixel = cnt_r == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      x_r  <= swap ? exc : sx;
      y_r  <= swap ? eyc : sy;
      ex_r <= swap ? sx  : exc;
      ey_r <= swap ? sy  : eyc;
    end else if (state_r == ST_SETUP) begin
      d_r     <= d_set;
      inc_a_r <= inc_a_set;
      inc_b_r <= inc_b_set;
      oct_r   <= oct_set;
      cnt_r   <= steps;
    end else if (state_r == ST_EMIT && out_acc && (cnt_r != '0)) begin
      d_r   <= d_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== sv/lpr_checker.sv =====
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks for the line pixel rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lpr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input lpr_pkg::coord_t out_pixel_x,
  input lpr_pkg::coord_t out_pixel_y,
  input logic           out_last_pixel
);
  import lpr_pkg::*;

  // A segment is never taken while its pixels are still being delivered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("segment word accepted while pixels are pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a segment was taken");

  // Columns never decrease and advance by at most one along a segment.
  a_x_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_pixel) |=>
      (out_valid && (out_pixel_x == $past(out_pixel_x) ||
                     out_pixel_x == $past(out_pixel_x) + 6'd1)))
    else $error("pixel column does not follow the previous one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pixel_x) && $stable(out_pixel_y) &&
       $stable(out_last_pixel)))
    else $error("stalled pixel word changed");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_seg.valid),
  .in_ready       (in_seg.ready),
  .out_valid      (out_pix.valid),
  .out_ready      (out_pix.ready),
  .out_pixel_x    (out_pix.pixel_x),
  .out_pixel_y    (out_pix.pixel_y),
  .out_last_pixel (out_pix.last_pixel)
);

// ===== bench/tb_line_pixel_rasterizer.sv =====
// ----------------------------------------------------------------------------
// tb_line_pixel_rasterizer
// Self-checking bench for the midpoint line rasterizer. Segment words are
// sent through the segment channel and each accepted segment is expanded
// into its expected run of pixels by a midpoint walk kept in the bench. Every
// pixel word taken from the pixel channel is compared field by field with the
// oldest expected pixel. Directed segments cover the octants, the tie rules,
// swapped endpoints, equal columns and degenerate segments. Random segments
// follow under several sender and receiver idling mixes, and a long receiver
// hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_line_pixel_rasterizer;
  import lpr_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_word_t;

  logic clk;
  logic rst_n;

  lpr_seg_if seg_if ();
  lpr_pix_if pix_if ();

  line_pixel_rasterizer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (seg_if.sink),
    .out_pix (pix_if.source)
  );

  pixel_word_t expected_pixels[$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        recv_hold;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Appends one pixel to the tail of the expected queue.
  function automatic void queue_expected_pixel(pixel_word_t w);
    expected_pixels.insert(expected_pixels.size(), w);
  endfunction

  // Expands one segment into the pixels that the midpoint walk selects.
  function automatic void predict_line_pixels(coord_t sx, coord_t sy, coord_t ex,
                                              coord_t ey);
    int      x0, y0, x1, y1, t;
    int      dx, dy, ady, d, x, y, steps;
    octant_t oct;
    x0 = (sx > COORD_MAX) ? int'(COORD_MAX) : int'(sx);
    y0 = (sy > COORD_MAX) ? int'(COORD_MAX) : int'(sy);
    x1 = (ex > COORD_MAX) ? int'(COORD_MAX) : int'(ex);
    y1 = (ey > COORD_MAX) ? int'(COORD_MAX) : int'(ey);
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    ady = (dy < 0) ? -dy : dy;
    steps = (dx >= ady) ? dx : ady;
    x = x0;
    y = y0;
    if (dy >= 0 && dx >= ady) begin
      oct = OCT_SHALLOW_UP;
      d = 2 * dy - dx;
    end else if (dy >= 0) begin
      oct = OCT_STEEP_UP;
      d = dy - 2 * dx;
    end else if (dx >= ady) begin
      oct = OCT_SHALLOW_DOWN;
      d = 2 * dy + dx;
    end else begin
      oct = OCT_STEEP_DOWN;
      d = dy + 2 * dx;
    end
    queue_expected_pixel(pixel_word_t'{x[5:0], y[5:0], steps == 0});
    for (int i = 0; i < steps; i++) begin
      case (oct)
        OCT_SHALLOW_UP: begin
          if (d <= 0) begin
            d += 2 * dy; x++;
          end else begin
            d += 2 * (dy - dx); x++; y++;
          end
        end
        OCT_STEEP_UP: begin
          if (d > 0) begin
            d -= 2 * dx; y++;
          end else begin
            d += 2 * (dy - dx); x++; y++;
          end
        end
        OCT_SHALLOW_DOWN: begin
          if (d > 0) begin
            d += 2 * dy; x++;
          end else begin
            d += 2 * (dy + dx); x++; y--;
          end
        end
        default: begin
          if (d < 0) begin
            d += 2 * dx; y--;
          end else begin
            d += 2 * (dx + dy); x++; y--;
          end
        end
      endcase
      queue_expected_pixel(pixel_word_t'{x[5:0], y[5:0], i == steps - 1});
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Called at a rising edge; returns at the edge where the word was taken,
  // leaving valid high so that a following word can go out without a gap.
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(posedge clk);
    end
    seg_if.valid   <= 1'b1;
    seg_if.start_x <= sx;
    seg_if.start_y <= sy;
    seg_if.end_x   <= ex;
    seg_if.end_y   <= ey;
    do @(posedge clk); while (!seg_if.ready);
    predict_line_pixels(sx, sy, ex, ey);
  endtask

  task automatic wait_for_pixels_drained();
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic hold_off_receiver(int cycles);
    recv_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold <= 1'b0;
  endtask

  // Receiver side: ready is redrawn every cycle unless a hold-off is running.
  always @(posedge clk) begin
    if (!rst_n || recv_hold) begin
      pix_if.ready <= 1'b0;
    end else begin
      pix_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pixel_word_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected pixel word, x", int'(pix_if.pixel_x), -1);
      end else begin
        want = expected_pixels.pop_front();
        if (pix_if.pixel_x !== want.x) begin
          report_mismatch("pixel_x", int'(pix_if.pixel_x), int'(want.x));
        end
        if (pix_if.pixel_y !== want.y) begin
          report_mismatch("pixel_y", int'(pix_if.pixel_y), int'(want.y));
        end
        if (pix_if.last_pixel !== want.last) begin
          report_mismatch("last_pixel", int'(pix_if.last_pixel), int'(want.last));
        end
      end
    end
  end

  task automatic test_directed_segments();
    // Degenerate segments at both corners.
    send_segment(6'd0, 6'd0, 6'd0, 6'd0);
    send_segment(6'd63, 6'd63, 6'd63, 6'd63);
    // Full-length horizontal, vertical and diagonal runs.
    send_segment(6'd0, 6'd0, 6'd63, 6'd0);
    send_segment(6'd5, 6'd0, 6'd5, 6'd63);
    send_segment(6'd7, 6'd63, 6'd7, 6'd0);
    send_segment(6'd0, 6'd0, 6'd63, 6'd63);
    send_segment(6'd0, 6'd63, 6'd63, 6'd0);
    // Start to the right of the end, so the endpoints are swapped.
    send_segment(6'd63, 6'd0, 6'd0, 6'd63);
    send_segment(6'd63, 6'd63, 6'd0, 6'd0);
    send_segment(6'd40, 6'd5, 6'd30, 6'd50);
    send_segment(6'd50, 6'd2, 6'd1, 6'd20);
    // One segment per octant pair.
    send_segment(6'd0, 6'd0, 6'd63, 6'd20);
    send_segment(6'd10, 6'd0, 6'd30, 6'd63);
    send_segment(6'd0, 6'd40, 6'd50, 6'd10);
    send_segment(6'd3, 6'd60, 6'd20, 6'd1);
    // Slopes of exactly one half and two, where the decision value hits zero.
    send_segment(6'd0, 6'd0, 6'd10, 6'd5);
    send_segment(6'd0, 6'd0, 6'd5, 6'd10);
    send_segment(6'd0, 6'd10, 6'd10, 6'd5);
    send_segment(6'd0, 6'd10, 6'd5, 6'd0);
    // Single steps and an equal-column downward walk.
    send_segment(6'd0, 6'd0, 6'd1, 6'd0);
    send_segment(6'd0, 6'd0, 6'd1, 6'd1);
    send_segment(6'd1, 6'd0, 6'd0, 6'd1);
    send_segment(6'd7, 6'd20, 6'd7, 6'd3);
    send_segment(6'd42, 6'd21, 6'd21, 6'd42);
  endtask

  task automatic test_random_segments(int count);
    int sx, sy, ex, ey;
    for (int n = 0; n < count; n++) begin
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      if ($urandom_range(0, 1)) begin
        ex = $urandom_range(0, 63);
        ey = $urandom_range(0, 63);
      end else begin
        // Short segment around the start point.
        ex = sx + $urandom_range(0, 16) - 8;
        ey = sy + $urandom_range(0, 16) - 8;
        ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
        ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
      end
      send_segment(sx[5:0], sy[5:0], ex[5:0], ey[5:0]);
    end
  endtask

  // The receiver is held off while segments keep coming, so the block fills
  // and must drop ready on the segment channel.
  task automatic test_receiver_hold_off();
    fork
      hold_off_receiver(400);
    join_none
    for (int n = 0; n < 6; n++) begin
      send_segment(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    error_count = 0;
    rst_n          <= 1'b0;
    recv_hold      <= 1'b0;
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    seg_if.valid   <= 1'b0;
    seg_if.start_x <= '0;
    seg_if.start_y <= '0;
    seg_if.end_x   <= '0;
    seg_if.end_y   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_segments();
    test_receiver_hold_off();
    test_random_segments(42);
    set_idling(68, 0);
    test_random_segments(42);
    set_idling(0, 68);
    test_random_segments(42);
    set_idling(25, 25);
    test_random_segments(42);

    seg_if.valid <= 1'b0;
    wait_for_pixels_drained();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_line_pixel_rasterizer passed");
    end else begin
      $display("tb_line_pixel_rasterizer failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_line_pixel_rasterizer failed");
    $finish;
  end

endmodule
